// ----- design/ffpa_pkg.sv -----
// Package with shared types, constants and op and status codes for the page range allocator.
`default_nettype none
package ffpa_pkg;
    localparam int MAX_EXTENTS_DEF = 64;
    localparam int PAGE_BITS_DEF = 20;
    localparam int PAGE_W = 20;
    localparam int LEN_W = 21;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [LEN_W-1:0] page_count;
        logic [PAGE_W-1:0] start_page;
    } req_t;

    typedef struct packed {
        logic [PAGE_W-1:0] result_page;
        logic [1:0] status;
    } rsp_t;

    // Memory port bundle from the sequencer to the extent table.
    typedef struct packed {
        logic rd_en;
        logic [11:0] rd_addr;
        logic wr_en;
        logic [11:0] wr_addr;
        logic [PAGE_W-1:0] wr_start;
        logic [LEN_W-1:0] wr_len;
    } mem_req_t;
endpackage
`default_nettype wire

// ----- design/ffpa_table.sv -----
// Extent table memory: start page and length per entry, one write and one read port.
`default_nettype none
module ffpa_table
    import ffpa_pkg::*;
#(
    parameter int MAX_EXTENTS = MAX_EXTENTS_DEF,
    parameter int AW = $clog2(MAX_EXTENTS)
)
(
    input wire clk,
    input wire [AW-1:0] rd_addr,
    input wire rd_en,
    input wire [AW-1:0] wr_addr,
    input wire wr_en,
    input wire [PAGE_W+LEN_W-1:0] wr_data,
    output logic [PAGE_W+LEN_W-1:0] rd_data
);
    logic [PAGE_W+LEN_W-1:0] mem [MAX_EXTENTS];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// ----- design/first_fit_page_range_allocator.sv -----
// Top level: request sequencer, configuration registers and the extent table.
`default_nettype none
// The allocator keeps its free extents, sorted by start page, in one memory
// and serves one item at a time. An allocate or free walks the table through
// the registered memory read port, checking each entry once its read data is
// valid before it reads the next; an insert or a drop moves every later entry
// one place, one read and one write per entry. The result waits in an output
// register; the next item is taken once it is delivered.
module first_fit_page_range_allocator
    import ffpa_pkg::*;
#(
    parameter int MAX_EXTENTS = MAX_EXTENTS_DEF
)
(
    input wire clk,
    input wire rst_n,
    input wire psel,
    input wire penable,
    input wire pwrite,
    input wire [2:0] paddr,
    input wire [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready,
    input wire in_valid,
    output logic in_stall,
    input wire req_t in_data,
    output logic out_valid,
    input wire out_stall,
    output rsp_t out_data
);
    localparam int AW = (MAX_EXTENTS > 2) ? $clog2(MAX_EXTENTS) : 1;
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam logic [LEN_W:0] LEN_MAX = {1'b0, {LEN_W{1'b1}}};

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;   // read entry idx, wait
    localparam logic [3:0] S_CHK = 4'd2;    // entry idx data valid
    localparam logic [3:0] S_DROP = 4'd3;   // shift left from idx
    localparam logic [3:0] S_DROPW = 4'd4;
    localparam logic [3:0] S_NEXT = 4'd5;   // free: next entry read wait
    localparam logic [3:0] S_FDEC = 4'd6;   // free: decide
    localparam logic [3:0] S_INS = 4'd7;    // shift right from end
    localparam logic [3:0] S_INSW = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [19:0] base_reg;
    logic [20:0] pages_reg;
    logic [3:0] state_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] ins_pos_reg;
    req_t req_reg;
    logic have_prev_reg;
    logic [PAGE_W-1:0] prev_start_reg;
    logic [LEN_W-1:0] prev_len_reg;
    logic [PAGE_W-1:0] cur_start_reg;
    logic [LEN_W-1:0] cur_len_reg;
    logic out_valid_reg;
    rsp_t out_reg;

    logic rd_en;
    logic [AW-1:0] rd_addr;
    logic wr_en;
    logic [AW-1:0] wr_addr;
    logic [PAGE_W+LEN_W-1:0] wr_data;
    logic [PAGE_W+LEN_W-1:0] rd_data;
    logic [PAGE_W-1:0] rd_start;
    logic [LEN_W-1:0] rd_len;

    assign rd_start = rd_data[PAGE_W+LEN_W-1:LEN_W];
    assign rd_len = rd_data[LEN_W-1:0];

    ffpa_table #(.MAX_EXTENTS(MAX_EXTENTS), .AW(AW)) u_table (
        .clk(clk), .rd_addr(rd_addr), .rd_en(rd_en), .wr_addr(wr_addr),
        .wr_en(wr_en), .wr_data(wr_data), .rd_data(rd_data)
    );

    // Configuration port.
    assign pready = 1'b1;
    always_comb
    begin
        case (paddr[2])
            1'b0: prdata = {12'd0, base_reg};
            default: prdata = {11'd0, pages_reg};
        endcase
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            pages_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'd0)
        begin
            if (paddr[2] == 1'b0)
                base_reg <= pwdata[19:0];
            else
                pages_reg <= pwdata[20:0];
        end
    end

    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    // Adjacency tests for free; done without wrap.
    logic [LEN_W:0] prev_end;
    logic [LEN_W:0] req_end;
    logic [LEN_W:0] prev_sum;
    logic [LEN_W:0] join_len;
    logic [LEN_W:0] next_sum;
    logic join_prev;
    logic join_next;
    logic cur_ok;
    assign prev_end = {2'b0, prev_start_reg} + {1'b0, prev_len_reg};
    assign req_end = {2'b0, req_reg.start_page} + {1'b0, req_reg.page_count};
    assign prev_sum = {1'b0, prev_len_reg} + {1'b0, req_reg.page_count};
    assign join_prev = have_prev_reg && prev_end == {2'b0, req_reg.start_page}
        && prev_sum <= LEN_MAX;
    assign join_len = join_prev ? prev_sum : {1'b0, req_reg.page_count};
    assign next_sum = join_len + {1'b0, cur_len_reg};
    assign cur_ok = idx_reg < count_reg;
    assign join_next = cur_ok && req_end == {2'b0, cur_start_reg}
        && next_sum <= LEN_MAX;

    logic [LEN_W-1:0] alloc_left;
    logic [PAGE_W-1:0] alloc_start;
    assign alloc_left = rd_len - req_reg.page_count;
    assign alloc_start = rd_start + req_reg.page_count[PAGE_W-1:0];

    // Sequencer read side.
    logic [3:0] state_next;
    always_comb
    begin
        rd_en = 1'b0;
        rd_addr = idx_reg[AW-1:0];
        state_next = state_reg;
        case (state_reg)
            S_SCAN: begin
                rd_en = 1'b1;
                state_next = S_CHK;
            end
            S_DROP: begin
                rd_en = 1'b1;
                rd_addr = AW'(idx_reg + 1'b1);
                state_next = S_DROPW;
            end
            S_DROPW: begin
                state_next = S_DROP;
            end
            S_INS: begin
                rd_en = 1'b1;
                rd_addr = AW'(idx_reg - 1'b1);
                state_next = S_INSW;
            end
            S_INSW: begin
                state_next = S_INS;
            end
            default: begin
            end
        endcase
        if (state_reg == S_SCAN && req_reg.op == OP_FREE && !cur_ok)
        begin
            rd_en = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            req_reg <= in_data;
        end
    end

    // Control flow with its writes, done in a clocked block around the table port.
    logic twr_en;
    logic [AW-1:0] twr_addr;
    logic [PAGE_W+LEN_W-1:0] twr_data;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg <= '0;
            ins_pos_reg <= '0;
            out_valid_reg <= 1'b0;
            out_reg <= '0;
            have_prev_reg <= 1'b0;
            prev_start_reg <= '0;
            prev_len_reg <= '0;
            cur_start_reg <= '0;
            cur_len_reg <= '0;
            twr_en <= 1'b0;
            twr_addr <= '0;
            twr_data <= '0;
        end
        else
        begin
            twr_en <= 1'b0;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (in_valid && !in_stall)
                    begin
                        idx_reg <= '0;
                        have_prev_reg <= 1'b0;
                        out_reg.result_page <= '0;
                        out_reg.status <= ST_OK;
                        if (in_data.op == OP_CLEAR)
                        begin
                            if (pages_reg != '0)
                            begin
                                twr_en <= 1'b1;
                                twr_addr <= '0;
                                twr_data <= {base_reg, pages_reg};
                                count_reg <= CW'(1);
                            end
                            else
                                count_reg <= '0;
                            state_reg <= S_DONE;
                        end
                        else if ((in_data.op == OP_ALLOC || in_data.op == OP_FREE)
                            && in_data.page_count != '0)
                        begin
                            if (in_data.op == OP_ALLOC && count_reg == '0)
                            begin
                                out_reg.status <= ST_NOFIT;
                                state_reg <= S_DONE;
                            end
                            else
                                state_reg <= S_SCAN;
                        end
                        else
                            state_reg <= S_DONE;
                    end
                end
                S_SCAN: begin
                    if (req_reg.op == OP_FREE && !cur_ok)
                        state_reg <= S_FDEC;
                    else
                        state_reg <= state_next;
                end
                S_CHK: begin
                    if (req_reg.op == OP_ALLOC)
                    begin
                        if (rd_len >= req_reg.page_count)
                        begin
                            out_reg.result_page <= rd_start;
                            if (alloc_left == '0)
                                state_reg <= S_DROP;
                            else
                            begin
                                twr_en <= 1'b1;
                                twr_addr <= idx_reg[AW-1:0];
                                twr_data <= {alloc_start, alloc_left};
                                state_reg <= S_DONE;
                            end
                        end
                        else if (idx_reg + 1'b1 >= count_reg)
                        begin
                            out_reg.status <= ST_NOFIT;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                            state_reg <= S_SCAN;
                        end
                    end
                    else
                    begin
                        cur_start_reg <= rd_start;
                        cur_len_reg <= rd_len;
                        if (req_reg.start_page > rd_start)
                        begin
                            have_prev_reg <= 1'b1;
                            prev_start_reg <= rd_start;
                            prev_len_reg <= rd_len;
                            idx_reg <= idx_reg + 1'b1;
                            state_reg <= S_SCAN;
                        end
                        else
                            state_reg <= S_FDEC;
                    end
                end
                S_FDEC: begin
                    if (join_prev)
                    begin
                        twr_en <= 1'b1;
                        twr_addr <= AW'(idx_reg - 1'b1);
                        twr_data <= {prev_start_reg,
                            join_next ? next_sum[LEN_W-1:0] : join_len[LEN_W-1:0]};
                        state_reg <= join_next ? S_DROP : S_DONE;
                    end
                    else if (join_next)
                    begin
                        twr_en <= 1'b1;
                        twr_addr <= idx_reg[AW-1:0];
                        twr_data <= {req_reg.start_page, next_sum[LEN_W-1:0]};
                        state_reg <= S_DONE;
                    end
                    else if (count_reg >= CW'(MAX_EXTENTS))
                    begin
                        out_reg.status <= ST_FULL;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        // Remember the insert position, then shift from the end down to it.
                        ins_pos_reg <= idx_reg;
                        idx_reg <= count_reg;
                        state_reg <= S_INS;
                        if (idx_reg == count_reg)
                            state_reg <= S_INSW;
                    end
                end
                S_DROP: begin
                    if (idx_reg + 1'b1 >= count_reg)
                    begin
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_DROPW;
                end
                S_DROPW: begin
                    idx_reg <= idx_reg + 1'b1;
                    state_reg <= S_DROP;
                end
                S_INS: begin
                    state_reg <= S_INSW;
                end
                S_INSW: begin
                    if (idx_reg == ins_pos_reg)
                    begin
                        twr_en <= 1'b1;
                        twr_addr <= idx_reg[AW-1:0];
                        twr_data <= {req_reg.start_page, req_reg.page_count};
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg - 1'b1;
                        state_reg <= S_INS;
                    end
                end
                S_DONE: begin
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Table writes: shift moves from the sequencer, single updates from the registered port.
    always_comb
    begin
        wr_en = twr_en;
        wr_addr = twr_addr;
        wr_data = twr_data;
        if (state_reg == S_DROPW)
        begin
            wr_en = 1'b1;
            wr_addr = idx_reg[AW-1:0];
            wr_data = rd_data;
        end
        else if (state_reg == S_INSW && idx_reg != ins_pos_reg)
        begin
            wr_en = 1'b1;
            wr_addr = idx_reg[AW-1:0];
            wr_data = rd_data;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("item accepted while busy");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_EXTENTS))
        else $error("extent count out of range");
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> out_valid)
        else $error("result lost");
`endif
endmodule
`default_nettype wire
